// ----- sv/erod_pkg.sv -----
package erod_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int COUNT_W  = 24;
	localparam int STATE_W  = 32;
	localparam int RES_W    = STATE_W + 1;
	localparam int MUL_A_W  = STATE_W + 3;
	localparam int MUL_B_W  = COEF_W + 2;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;

	localparam int REG_COUNT = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [COEF_W-1:0]  ALPHA_LP_RST    = COEF_W'(655);
	localparam logic [COEF_W-1:0]  ALPHA_ABS_RST   = COEF_W'(655);
	localparam logic [COEF_W-1:0]  THRESH_MULT_RST = COEF_W'(1024);
	localparam logic [COUNT_W-1:0] SETTLE_LP_RST   = COUNT_W'(((512*2*3)/2) * 6);
	localparam logic [COUNT_W-1:0] SETTLE_ABS_RST  = COUNT_W'((((512*2*3)/2) * 6) + 500);

	localparam logic [REG_IDX_W-1:0] REG_ALPHA_LP    = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_ALPHA_ABS   = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_THRESH_MULT = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_SETTLE_LP   = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_SETTLE_ABS  = REG_IDX_W'(REG_COUNT - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LP,
		ST_UPD_LP,
		ST_MUL_MAV,
		ST_UPD_MAV,
		ST_MUL_THR,
		ST_CMP,
		ST_DONE
	} erod_state_t;

	typedef struct packed {
		logic [COEF_W-1:0]  alpha_lp;
		logic [COEF_W-1:0]  alpha_abs;
		logic [COEF_W-1:0]  thresh_mult;
		logic [COUNT_W-1:0] settle_lp;
		logic [COUNT_W-1:0] settle_abs;
		logic               load_lp;
		logic               load_abs;
	} erod_cfg_t;

endpackage

// ----- sv/erod_mul.sv -----
module erod_mul
	import erod_pkg::*;
(
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [MUL_A_W-1:0]  a,
	input  logic signed [MUL_B_W-1:0]  b,
	output logic signed [PROD_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

// ----- sv/erod_core.sv -----
module erod_core
	import erod_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  erod_cfg_t           cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                res_valid,
	input  logic                res_ready,
	output logic                detect,
	output logic                settled
);

	erod_state_t state_q, state_d;

	logic [SAMPLE_W-1:0] samp_q;
	logic [STATE_W-1:0]  lp_q;
	logic [STATE_W-1:0]  mav_q;
	logic [RES_W-1:0]    res_q;
	logic                first_q;
	logic [COUNT_W-1:0]  lp_left_q;
	logic [COUNT_W-1:0]  abs_left_q;
	logic                det_q;
	logic                set_q;

	logic                      in_fire;
	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic [STATE_W-1:0]        sq;
	logic [RES_W-1:0]          diff;
	logic [RES_W-1:0]          ares;
	logic [RES_W:0]            mav_diff;
	logic [STATE_W-1:0]        step;
	logic                      over;

	assign in_fire = in_valid && in_ready;
	assign sq      = {samp_q, {(STATE_W-SAMPLE_W){1'b0}}};
	// residual against the current low-pass state; also the lp filter error term
	assign diff     = {sq[STATE_W-1], sq} - {lp_q[STATE_W-1], lp_q};
	assign ares     = diff[RES_W-1] ? (~diff + RES_W'(1)) : diff;
	assign mav_diff = {1'b0, ares} - {2'b00, mav_q};
	assign step     = prod_q[STATE_W+15:16];
	// rising residual, res * 2^8 against mav * thresh (both Q.24)
	assign over = !res_q[RES_W-1] && (res_q != '0) &&
		({8'h00, res_q[STATE_W-1:0], 8'h00} > prod_q[STATE_W+15:0]);

	erod_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_MUL_LP;
				end
			end
			ST_MUL_LP: begin
				mul_en  = 1'b1;
				mul_a   = MUL_A_W'($signed(diff));
				mul_b   = {2'b00, cfg.alpha_lp};
				state_d = ST_UPD_LP;
			end
			ST_UPD_LP: begin
				state_d = (lp_left_q != '0) ? ST_DONE : ST_MUL_MAV;
			end
			ST_MUL_MAV: begin
				mul_en  = 1'b1;
				mul_a   = MUL_A_W'($signed(mav_diff));
				mul_b   = {2'b00, cfg.alpha_abs};
				state_d = ST_UPD_MAV;
			end
			ST_UPD_MAV: begin
				state_d = (abs_left_q != '0) ? ST_DONE : ST_MUL_THR;
			end
			ST_MUL_THR: begin
				mul_en  = 1'b1;
				mul_a   = {3'b000, mav_q};
				mul_b   = {2'b00, cfg.thresh_mult};
				state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= 1'b1;
			lp_left_q  <= SETTLE_LP_RST;
			abs_left_q <= SETTLE_ABS_RST;
		end else begin
			if (in_fire) begin
				first_q <= 1'b0;
			end
			if (cfg.load_lp) begin
				lp_left_q <= cfg.settle_lp;
			end else if (state_q == ST_UPD_LP && lp_left_q != '0) begin
				lp_left_q <= lp_left_q - COUNT_W'(1);
			end
			if (cfg.load_abs) begin
				abs_left_q <= cfg.settle_abs;
			end else if (state_q == ST_UPD_MAV && abs_left_q != '0) begin
				abs_left_q <= abs_left_q - COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q  <= '0;
			mav_q <= '0;
		end else begin
			if (in_fire && first_q) begin
				lp_q <= {sample, {(STATE_W-SAMPLE_W){1'b0}}};
			end else if (state_q == ST_UPD_LP) begin
				lp_q <= lp_q + step;
			end
			if (state_q == ST_UPD_MAV) begin
				mav_q <= mav_q + step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			samp_q <= sample;
		end
		if (state_q == ST_MUL_MAV) begin
			res_q <= diff;
		end
		case (state_q)
			ST_UPD_LP: begin
				det_q <= 1'b0;
				set_q <= 1'b0;
			end
			ST_UPD_MAV: begin
				det_q <= 1'b0;
				set_q <= 1'b0;
			end
			ST_CMP: begin
				det_q <= over;
				set_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign detect  = det_q;
	assign settled = set_q;

	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !first_q)
		else $error("first-sample flag still set after a sample");

	a_settled_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && set_q) |-> (lp_left_q == '0 && abs_left_q == '0))
		else $error("settled result while a settle count is nonzero");

	a_detect_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && det_q) |-> set_q)
		else $error("detect without settled");

	a_upd_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD_LP) |-> $past(state_q) == ST_MUL_LP)
		else $error("low-pass update without its product");

endmodule

// ----- sv/ema_residual_onset_detector.sv -----
// Per sample: low-pass multiply and update; once the low-pass has settled, mav multiply
// and update; once the mav has settled, threshold multiply and compare; then the result
// word, which may stall on the output. One sample is taken at a time; one shared 35x18
// multiplier serves the low-pass, mav and threshold products in turn.
// Reset (arst_n low): filter states clear, settle counters and registers load
// their defaults, first sample reloads the low-pass state.
module ema_residual_onset_detector
	import erod_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,   // [15:0] sample
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,   // [0] detect, [7:1] zero
	output logic                 m_axis_tuser,   // [0] settled
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_data
);

	erod_cfg_t cfg;

	logic [COEF_W-1:0]  alpha_lp_q;
	logic [COEF_W-1:0]  alpha_abs_q;
	logic [COEF_W-1:0]  thresh_mult_q;
	logic               cfg_fire;

	logic res_valid;
	logic res_ready;
	logic res_detect;
	logic res_settled;
	logic out_valid_q;
	logic detect_q;
	logic settled_q;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// settle words go straight into the core counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_lp_q    <= ALPHA_LP_RST;
			alpha_abs_q   <= ALPHA_ABS_RST;
			thresh_mult_q <= THRESH_MULT_RST;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_ALPHA_LP:    alpha_lp_q    <= cfg_data[COEF_W-1:0];
				REG_ALPHA_ABS:   alpha_abs_q   <= cfg_data[COEF_W-1:0];
				REG_THRESH_MULT: thresh_mult_q <= cfg_data[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.alpha_lp    = alpha_lp_q;
		cfg.alpha_abs   = alpha_abs_q;
		cfg.thresh_mult = thresh_mult_q;
		cfg.settle_lp   = cfg_data;
		cfg.settle_abs  = cfg_data;
		cfg.load_lp     = cfg_fire && (cfg_index == REG_SETTLE_LP);
		cfg.load_abs    = cfg_fire && (cfg_index == REG_SETTLE_ABS);
	end

	erod_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.sample    (s_axis_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.detect    (res_detect),
		.settled   (res_settled)
	);

	// output word register; core may finish while the previous word drains
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			detect_q  <= res_detect;
			settled_q <= res_settled;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0000000, detect_q};
	assign m_axis_tuser  = settled_q;

endmodule

// ----- tb/sv/ema_residual_onset_detector_test.sv -----
`timescale 1ns / 1ps

module ema_residual_onset_detector_test;
	import erod_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 1700;
	localparam int MAX_SHOWN      = 10;
	localparam int TAIL_CYCLES    = 20;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = '1;

	typedef enum logic {DO_SAMPLE, DO_WRITE} step_kind_t;

	typedef struct packed {
		step_kind_t           kind;
		logic [REG_IDX_W-1:0] idx;
		logic [COUNT_W-1:0]   data;
		logic                 fixed;
		logic                 detect;
		logic                 settled;
	} step_t;

	typedef struct packed {
		logic detect;
		logic settled;
	} onset_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [COUNT_W-1:0]   cfg_data = '0;

	// result pinned to the word on the bus, for rows with a known answer
	logic pin_fixed = 1'b0;
	logic pin_detect = 1'b0;
	logic pin_settled = 1'b0;

	int snd_idle = 0;
	int rcv_idle = 0;
	int mismatches = 0;
	int quiet = 0;

	onset_t onset_q[$];

	// tracker copy of the block
	logic [COEF_W-1:0]         k_alpha_lp;
	logic [COEF_W-1:0]         k_alpha_abs;
	logic [COEF_W-1:0]         k_thresh;
	logic signed [STATE_W-1:0] lp_state;
	logic [STATE_W-1:0]        mav_state;
	logic                      lp_unloaded;
	logic [COUNT_W-1:0]        lp_hold;
	logic [COUNT_W-1:0]        abs_hold;

	step_t plan [0:35] = '{
		// default hold-off right after reset
		'{DO_SAMPLE, '0, 24'h007FFF, 1'b1, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h008000, 1'b1, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h000000, 1'b1, 1'b0, 1'b0},
		// no hold-off, zero threshold
		'{DO_WRITE, REG_SETTLE_LP, 24'h000000, 1'b0, 1'b0, 1'b0},
		'{DO_WRITE, REG_SETTLE_ABS, 24'h000000, 1'b0, 1'b0, 1'b0},
		'{DO_WRITE, REG_THRESH_MULT, 24'h000000, 1'b0, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h007FFF, 1'b0, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h008000, 1'b0, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h000001, 1'b0, 1'b0, 1'b0},
		// alpha extremes, top threshold
		'{DO_WRITE, REG_ALPHA_LP, 24'h00FFFF, 1'b0, 1'b0, 1'b0},
		'{DO_WRITE, REG_ALPHA_ABS, 24'h000001, 1'b0, 1'b0, 1'b0},
		'{DO_WRITE, REG_THRESH_MULT, 24'h00FFFF, 1'b0, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h008000, 1'b0, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h007FFF, 1'b0, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h00FFFF, 1'b0, 1'b0, 1'b0},
		// dead index is dropped; zero alphas freeze both filters
		'{DO_WRITE, REG_UNMAPPED, 24'hFFFFFF, 1'b0, 1'b0, 1'b0},
		'{DO_WRITE, REG_ALPHA_LP, 24'h000000, 1'b0, 1'b0, 1'b0},
		'{DO_WRITE, REG_ALPHA_ABS, 24'h000000, 1'b0, 1'b0, 1'b0},
		'{DO_WRITE, REG_THRESH_MULT, 24'h000100, 1'b0, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h005555, 1'b0, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h00AAAA, 1'b0, 1'b0, 1'b0},
		// longest hold-off
		'{DO_WRITE, REG_ALPHA_LP, 24'h000800, 1'b0, 1'b0, 1'b0},
		'{DO_WRITE, REG_ALPHA_ABS, 24'h000800, 1'b0, 1'b0, 1'b0},
		'{DO_WRITE, REG_SETTLE_LP, 24'hFFFFFF, 1'b0, 1'b0, 1'b0},
		'{DO_WRITE, REG_SETTLE_ABS, 24'hFFFFFF, 1'b0, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h001234, 1'b1, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h00C000, 1'b1, 1'b0, 1'b0},
		// short counts run out: two low-pass, three mav, then settled
		'{DO_WRITE, REG_SETTLE_LP, 24'h000002, 1'b0, 1'b0, 1'b0},
		'{DO_WRITE, REG_SETTLE_ABS, 24'h000003, 1'b0, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h000100, 1'b1, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h000200, 1'b1, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h007000, 1'b1, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h00F000, 1'b1, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h000010, 1'b1, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h007FFF, 1'b0, 1'b0, 1'b0},
		'{DO_SAMPLE, '0, 24'h000000, 1'b0, 1'b0, 1'b0}
	};

	ema_residual_onset_detector u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void clear_tracker();
		k_alpha_lp  = 16'd655;
		k_alpha_abs = 16'd655;
		k_thresh    = 16'd1024;
		lp_state    = '0;
		mav_state   = '0;
		lp_unloaded = 1'b1;
		lp_hold     = 24'd9216;
		abs_hold    = 24'd9716;
	endfunction

	function automatic void load_reg(logic [REG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
		case (idx)
			REG_ALPHA_LP:    k_alpha_lp = val[COEF_W-1:0];
			REG_ALPHA_ABS:   k_alpha_abs = val[COEF_W-1:0];
			REG_THRESH_MULT: k_thresh = val[COEF_W-1:0];
			REG_SETTLE_LP:   lp_hold = val;
			REG_SETTLE_ABS:  abs_hold = val;
			default: ;
		endcase
	endfunction

	// Q16.16 states, floor after each weighted sum
	function automatic onset_t track_sample(logic [15:0] raw);
		longint x, wa, wb, acc, resid;
		longint unsigned mag, ma, mb, macc, thr, lifted;
		onset_t r;
		r = '0;
		x = longint'($signed(raw)) <<< 16;
		if (lp_unloaded) begin
			lp_state = x[STATE_W-1:0];
			lp_unloaded = 1'b0;
		end
		wa = longint'(k_alpha_lp);
		wb = 65536 - wa;
		acc = wa * x + wb * longint'(lp_state);
		acc = acc >>> 16;
		lp_state = acc[STATE_W-1:0];
		if (lp_hold != 0) begin
			lp_hold--;
			return r;
		end
		resid = x - longint'(lp_state);
		mag = (resid < 0) ? -resid : resid;
		ma = 64'(k_alpha_abs);
		mb = 65536 - ma;
		macc = (ma * mag + mb * mav_state) >> 16;
		mav_state = macc[STATE_W-1:0];
		if (abs_hold != 0) begin
			abs_hold--;
			return r;
		end
		r.settled = 1'b1;
		thr = 64'(mav_state);
		thr = thr * k_thresh;
		lifted = resid;
		lifted = lifted << 8;
		r.detect = (resid > 0) && (lifted > thr);
		return r;
	endfunction

	task automatic flag(string what, longint want, longint got);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		onset_t r;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			r = track_sample(s_axis_tdata);
			if (pin_fixed)
				r = '{detect: pin_detect, settled: pin_settled};
			onset_q.push_back(r);
		end
		if (arst_n && cfg_valid && cfg_ready)
			load_reg(cfg_index, cfg_data);
	end

	always @(posedge clk) begin
		onset_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (onset_q.size() == 0) begin
				flag("result word with none pending", 0, longint'(m_axis_tdata));
			end else begin
				want = onset_q.pop_front();
				if (m_axis_tdata[0] !== want.detect)
					flag("detect", longint'(want.detect), longint'(m_axis_tdata[0]));
				if (m_axis_tuser !== want.settled)
					flag("settled", longint'(want.settled), longint'(m_axis_tuser));
				if (m_axis_tdata[7:1] !== 7'd0)
					flag("tdata pad bits", 0, longint'(m_axis_tdata[7:1]));
			end
		end
	end

	// counts cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("ema_residual_onset_detector: mismatch");
			$finish;
		end
	end

	task automatic send_word(logic [15:0] raw, logic fixed, logic det, logic set);
		if ($urandom_range(99) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= raw;
		pin_fixed     <= fixed;
		pin_detect    <= det;
		pin_settled   <= set;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_results_out();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (onset_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
		wait_results_out();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [COUNT_W-1:0] alpha_word();
		case ($urandom_range(5))
			0: return 24'h000001;
			1: return 24'hFFFFFF;   // upper byte is dropped
			2: return 24'($urandom);
			default: return 24'(1) << $urandom_range(15, 9);
		endcase
	endfunction

	task automatic retune();
		logic [COUNT_W-1:0] thr;
		write_reg(REG_ALPHA_LP, alpha_word());
		write_reg(REG_ALPHA_ABS, alpha_word());
		case ($urandom_range(5))
			0: thr = '0;
			1: thr = 24'hFFFFFF;
			default: thr = 24'($urandom_range(1536, 128));
		endcase
		write_reg(REG_THRESH_MULT, thr);
		write_reg(REG_SETTLE_LP, 24'($urandom_range(40)));
		write_reg(REG_SETTLE_ABS, 24'($urandom_range(40)));
		if ($urandom_range(3) == 0)
			write_reg(REG_UNMAPPED, 24'($urandom));
	endtask

	// steady baseline with jitter, level steps, positive spikes and some wild words
	task automatic run_phase(int unsigned count);
		int base, spread, v;
		int unsigned pick;
		logic [15:0] raw;
		base = int'($urandom_range(50000)) - 25000;
		spread = 1 << $urandom_range(11);
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				raw = 16'($urandom);
			end else begin
				if (pick < 11)
					base = int'($urandom_range(65535)) - 32768;
				v = base + int'($urandom_range(2 * spread)) - spread;
				if (pick >= 11 && pick < 18)
					v = v + int'($urandom_range(30000, 1000));
				if (v > 32767)
					v = 32767;
				else if (v < -32768)
					v = -32768;
				raw = 16'(v);
			end
			send_word(raw, 1'b0, 1'b0, 1'b0);
		end
	endtask

	initial begin
		int unsigned sent;
		int unsigned n;
		clear_tracker();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		snd_idle = 30;
		rcv_idle = 58;
		foreach (plan[i]) begin
			if (plan[i].kind == DO_WRITE)
				write_reg(plan[i].idx, plan[i].data);
			else
				send_word(plan[i].data[15:0], plan[i].fixed, plan[i].detect,
					plan[i].settled);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= 2 * RANDOM_ITEMS / 3) begin
				snd_idle = 0;
				rcv_idle = 0;
			end else if (sent >= RANDOM_ITEMS / 3) begin
				snd_idle = 58;
				rcv_idle = 30;
			end
			retune();
			n = $urandom_range(140, 60);
			run_phase(n);
			sent += n;
		end

		wait_results_out();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (onset_q.size() != 0)
			flag("result words never delivered", 0, longint'(onset_q.size()));
		if (mismatches == 0)
			$display("ema_residual_onset_detector: match");
		else
			$display("ema_residual_onset_detector: mismatch");
		$finish;
	end

endmodule
